// ===== hw/rtl/pku_pkg.sv =====
// Package for the particle kinematic update block: fixed-point widths,
// configuration reset value and the input / result payload structs.
// No dependencies.
`default_nettype none

package pku_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int DT_BITS    = FRAC_BITS + 1;

    localparam logic [DT_BITS-1:0] DT_RESET = DT_BITS'(655);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] pos_x;
        logic signed [VALUE_BITS-1:0] pos_y;
        logic signed [VALUE_BITS-1:0] vel_x;
        logic signed [VALUE_BITS-1:0] vel_y;
        logic signed [VALUE_BITS-1:0] force_x;
        logic signed [VALUE_BITS-1:0] force_y;
        logic        [VALUE_BITS-1:0] mass;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] new_pos_x;
        logic signed [VALUE_BITS-1:0] new_pos_y;
        logic signed [VALUE_BITS-1:0] new_vel_x;
        logic signed [VALUE_BITS-1:0] new_vel_y;
        logic                         saturated;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/particle_kinematic_update.sv =====
// Particle kinematic update, top level: divider pipeline plus integration stages.
// Depends on pku_pkg (widths, payload structs).
//
// One particle record is taken per clock (start high, busy low) and its
// update comes back on o_out, qualified by o_done for exactly one cycle
// (default Q16.16 format). busy is never raised: the receiver cannot
// stall and the pipeline never holds, so the sustained rate is one record
// per cycle at any mix of idle and busy input cycles. A record passes
// through an entry register and the acceleration divider, which resolves
// one quotient bit per pipeline stage (VALUE_BITS+FRAC_BITS stages),
// followed by a multiply stage, a combine/clamp stage and a sum/saturate
// stage. The time step is written through the cfg channel (always ready);
// its square is registered at the write, so write it only while no record
// is in flight.
`default_nettype none

module particle_kinematic_update
    import pku_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // record channel
    input  wire logic                 start,
    output      logic                 busy,
    input  wire t_in_item             i_in,
    // result channel
    output      logic                 o_done,
    output      t_out_item            o_out,
    // dt_step configuration channel
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [DT_BITS-1:0]   i_cfg_data
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int VB  = VALUE_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int QW  = VB + FB;          // numerator / quotient width
    localparam int D2W = 2 * DT_BITS;      // dt squared
    localparam int ALW = QW / 2;           // low half of acceleration
    localparam int AHW = QW - ALW;         // high half of acceleration
    localparam int AW1 = QW + DT_BITS;     // a*dt full product
    localparam int AW2 = QW + D2W;         // a*dt*dt full product
    localparam int CW  = VB + 3;           // clamped term magnitude
    localparam int SW  = VB + 4;           // exact sum width

    // Terms beyond this magnitude saturate the result anyway.
    localparam logic [AW2-1:0] TERM_CLAMP = AW2'(1) << (VB + 2);

    // ------------------------------------------------------------------
    // Stage payload types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [VB-1:0] pos;
        logic [VB-1:0] vel;
        logic [VB-1:0] vm;      // |vel|
        logic          vneg;
        logic          fneg;
        logic [VB-1:0] rem;     // partial remainder
        logic [QW-1:0] nq;      // numerator bits shifting out, quotient in
    } t_axis_div;

    typedef struct packed {
        logic [VB-1:0] mass;
        t_axis_div     x;
        t_axis_div     y;
    } t_div;

    typedef struct packed {
        logic [VB-1:0]          pos;
        logic [VB-1:0]          vel;
        logic                   vneg;
        logic                   fneg;
        logic [VB+DT_BITS-1:0]  v1p;
        logic [ALW+DT_BITS-1:0] adt_lo;
        logic [AHW+DT_BITS-1:0] adt_hi;
        logic [ALW+D2W-1:0]     a2_lo;
        logic [AHW+D2W-1:0]     a2_hi;
    } t_axis_p1;

    typedef struct packed {
        logic [VB-1:0] pos;
        logic [VB-1:0] vel;
        logic          vneg;
        logic          fneg;
        logic [VB-1:0] v1;      // vel*dt, always below 2^VB
        logic [CW-1:0] adt;     // a*dt, clamped
        logic [CW-1:0] adt2;    // a*dt*dt/2, clamped
    } t_axis_p2;

    typedef struct packed {
        t_axis_p1 x;
        t_axis_p1 y;
    } t_p1;

    typedef struct packed {
        t_axis_p2 x;
        t_axis_p2 y;
    } t_p2;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [VB-1:0] magnitude(logic [VB-1:0] v);
        return v[VB-1] ? (~v + VB'(1)) : v;
    endfunction

    function automatic t_axis_div axis_entry(logic [VB-1:0] pos, logic [VB-1:0] vel,
                                             logic [VB-1:0] frc);
        t_axis_div a;
        a.pos  = pos;
        a.vel  = vel;
        a.vm   = magnitude(vel);
        a.vneg = vel[VB-1];
        a.fneg = frc[VB-1];
        a.rem  = '0;
        a.nq   = {magnitude(frc), {FB{1'b0}}};
        return a;
    endfunction

    // One restoring-division step: one quotient bit.
    function automatic t_axis_div div_step(t_axis_div a, logic [VB-1:0] m);
        t_axis_div r;
        logic [VB:0] sh;
        logic [VB:0] diff;
        r    = a;
        sh   = {a.rem, a.nq[QW-1]};
        diff = sh - {1'b0, m};
        r.nq = {a.nq[QW-2:0], 1'b0};
        if (sh >= {1'b0, m}) begin
            r.rem   = diff[VB-1:0];
            r.nq[0] = 1'b1;
        end else begin
            r.rem   = sh[VB-1:0];
        end
        return r;
    endfunction

    function automatic t_axis_p1 axis_mul(t_axis_div a, logic [DT_BITS-1:0] dt,
                                          logic [D2W-1:0] dt_sq);
        t_axis_p1 p;
        p.pos    = a.pos;
        p.vel    = a.vel;
        p.vneg   = a.vneg;
        p.fneg   = a.fneg;
        p.v1p    = (VB+DT_BITS)'(a.vm) * (VB+DT_BITS)'(dt);
        p.adt_lo = (ALW+DT_BITS)'(a.nq[ALW-1:0]) * (ALW+DT_BITS)'(dt);
        p.adt_hi = (AHW+DT_BITS)'(a.nq[QW-1:ALW]) * (AHW+DT_BITS)'(dt);
        p.a2_lo  = (ALW+D2W)'(a.nq[ALW-1:0]) * (ALW+D2W)'(dt_sq);
        p.a2_hi  = (AHW+D2W)'(a.nq[QW-1:ALW]) * (AHW+D2W)'(dt_sq);
        return p;
    endfunction

    function automatic logic [CW-1:0] clamp_term(logic [AW2-1:0] v);
        return (v > TERM_CLAMP) ? TERM_CLAMP[CW-1:0] : v[CW-1:0];
    endfunction

    function automatic t_axis_p2 axis_combine(t_axis_p1 p);
        t_axis_p2 q;
        logic [AW1-1:0] adt_full;
        logic [AW2-1:0] a2_full;
        adt_full = (AW1'(p.adt_hi) << ALW) + AW1'(p.adt_lo);
        a2_full  = (AW2'(p.a2_hi) << ALW) + AW2'(p.a2_lo);
        q.pos    = p.pos;
        q.vel    = p.vel;
        q.vneg   = p.vneg;
        q.fneg   = p.fneg;
        // |vel| <= 2^(VB-1) and dt < 2^(FB+1), so the top product bit is zero
        q.v1     = p.v1p[FB +: VB];
        q.adt    = clamp_term(AW2'(adt_full >> FB));
        q.adt2   = clamp_term(a2_full >> (2 * FB + 1));
        return q;
    endfunction

    function automatic logic [SW-1:0] signed_term(logic [CW-1:0] m, logic neg);
        return neg ? (~SW'(m) + SW'(1)) : SW'(m);
    endfunction

    // {overflow flag, saturated value}
    function automatic logic [VB:0] saturate(logic [SW-1:0] s);
        logic ovf;
        ovf = !(&s[SW-1:VB-1]) && (|s[SW-1:VB-1]);
        if (!ovf) begin
            return {1'b0, s[VB-1:0]};
        end else if (s[SW-1]) begin
            return {1'b1, 1'b1, {(VB-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(VB-1){1'b1}}};
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration: dt and its square, squared at the write
    // ------------------------------------------------------------------
    logic [DT_BITS-1:0] r_dt;
    logic [D2W-1:0]     r_dt_sq;
    logic [D2W-1:0]     n_dt_sq;

    assign o_cfg_ready = 1'b1;
    assign n_dt_sq     = D2W'(i_cfg_data) * D2W'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= DT_RESET;
            r_dt_sq <= D2W'(DT_RESET) * D2W'(DT_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dt    <= i_cfg_data;
            r_dt_sq <= n_dt_sq;
        end
    end

    // ------------------------------------------------------------------
    // Entry stage and divider pipeline: stage k resolves quotient bit QW-k
    // ------------------------------------------------------------------
    logic         in_xfer;
    t_div         n_div0;
    t_div         r_div [0:QW];
    logic [QW:0]  r_div_vld;

    assign busy    = 1'b0;         // pipeline never holds
    assign in_xfer = start && !busy;

    always_comb begin
        // zero mass is taken as one LSB
        n_div0.mass = (i_in.mass == '0) ? VB'(1) : i_in.mass;
        n_div0.x    = axis_entry(i_in.pos_x, i_in.vel_x, i_in.force_x);
        n_div0.y    = axis_entry(i_in.pos_y, i_in.vel_y, i_in.force_y);
    end

    always_ff @(posedge i_clk) begin
        r_div[0] <= n_div0;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_div[k].mass <= r_div[k-1].mass;
            r_div[k].x    <= div_step(r_div[k-1].x, r_div[k-1].mass);
            r_div[k].y    <= div_step(r_div[k-1].y, r_div[k-1].mass);
        end
    end

    // ------------------------------------------------------------------
    // Multiply, combine/clamp, sum/saturate
    // ------------------------------------------------------------------
    t_p1       r_p1;
    t_p2       r_p2;
    logic      r_p1_vld;
    logic      r_p2_vld;
    logic      r_done;
    t_out_item r_out;
    t_out_item n_out;

    always_ff @(posedge i_clk) begin
        r_p1.x <= axis_mul(r_div[QW].x, r_dt, r_dt_sq);
        r_p1.y <= axis_mul(r_div[QW].y, r_dt, r_dt_sq);
        r_p2.x <= axis_combine(r_p1.x);
        r_p2.y <= axis_combine(r_p1.y);
        r_out  <= n_out;
    end

    always_comb begin
        logic [SW-1:0] px_sum;
        logic [SW-1:0] py_sum;
        logic [SW-1:0] vx_sum;
        logic [SW-1:0] vy_sum;
        logic [VB:0]   px_sat;
        logic [VB:0]   py_sat;
        logic [VB:0]   vx_sat;
        logic [VB:0]   vy_sat;
        px_sum = {{(SW-VB){r_p2.x.pos[VB-1]}}, r_p2.x.pos}
               + signed_term(CW'(r_p2.x.v1), r_p2.x.vneg)
               + signed_term(r_p2.x.adt2, r_p2.x.fneg);
        py_sum = {{(SW-VB){r_p2.y.pos[VB-1]}}, r_p2.y.pos}
               + signed_term(CW'(r_p2.y.v1), r_p2.y.vneg)
               + signed_term(r_p2.y.adt2, r_p2.y.fneg);
        vx_sum = {{(SW-VB){r_p2.x.vel[VB-1]}}, r_p2.x.vel}
               + signed_term(r_p2.x.adt, r_p2.x.fneg);
        vy_sum = {{(SW-VB){r_p2.y.vel[VB-1]}}, r_p2.y.vel}
               + signed_term(r_p2.y.adt, r_p2.y.fneg);
        px_sat = saturate(px_sum);
        py_sat = saturate(py_sum);
        vx_sat = saturate(vx_sum);
        vy_sat = saturate(vy_sum);
        n_out.new_pos_x = px_sat[VB-1:0];
        n_out.new_pos_y = py_sat[VB-1:0];
        n_out.new_vel_x = vx_sat[VB-1:0];
        n_out.new_vel_y = vy_sat[VB-1:0];
        n_out.saturated = px_sat[VB] | py_sat[VB] | vx_sat[VB] | vy_sat[VB];
    end

    // valid bits travel alongside the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_vld <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_div_vld <= {r_div_vld[QW-1:0], in_xfer};
            r_p1_vld  <= r_div_vld[QW];
            r_p2_vld  <= r_p1_vld;
            r_done    <= r_p2_vld;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

`default_nettype wire
